[src/lias_pkg.sv]
package lias_pkg;

  // Field widths fixed by the interface.
  localparam int RAW_W      = 16;
  localparam int PHASE_W    = 23;
  localparam int START_W    = 16;
  localparam int COUNT_W    = 24;
  localparam int TAIL_W     = 6;
  localparam int CFG_DATA_W = 24;
  localparam int ACC_W      = 32;
  localparam int DIFF_W     = RAW_W + 1;

  localparam int LIAS_MAX_UPSAMPLE = 32;

  // Reset values of the configuration registers.
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 23'h010000;
  localparam logic [TAIL_W-1:0]  TAIL_COUNT_RST = 6'd1;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 23'h010000;

  typedef logic [RAW_W-1:0]         raw_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [ACC_W-1:0]         acc_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  typedef enum logic [2:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_START_PHASE   = 3'd1,
    REG_MAIN_COUNT    = 3'd2,
    REG_TAIL_COUNT    = 3'd3,
    REG_IS_STEREO     = 3'd4,
    REG_SOURCE_WIDE   = 3'd5,
    REG_SOURCE_SIGNED = 3'd6,
    REG_OUT_FORMAT    = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    FMT_S8  = 2'd0,
    FMT_U8  = 2'd1,
    FMT_S16 = 2'd2,
    FMT_S16_ALT = 2'd3
  } out_fmt_t;

  // Operands of one multiply-accumulate: base*65536 + diff*weight.
  typedef struct packed {
    raw_t        base;
    diff_t       diff;
    logic [15:0] weight;
  } mac_op_t;

  // Convert a raw sample into offset binary.
  function automatic raw_t to_offset(raw_t raw, logic wide, logic sgn);
    raw_t r;
    if (wide) begin
      r = sgn ? (raw ^ 16'h8000) : raw;
    end else begin
      r = {8'h00, raw[7:0] ^ (sgn ? 8'h80 : 8'h00)};
    end
    return r;
  endfunction

  // Scale the blended offset-binary value and convert to the output format.
  function automatic raw_t format_out(acc_t acc, logic wide, out_fmt_t fmt);
    raw_t r;
    if (wide) begin
      r = acc[31:16] ^ 16'h8000;
    end else begin
      unique case (fmt)
        FMT_S8:  r = {8'h00, acc[23:16] ^ 8'h80};
        FMT_U8:  r = {8'h00, acc[23:16]};
        default: r = acc[23:8] ^ 16'h8000;
      endcase
    end
    return r;
  endfunction

endpackage

[src/lias_mac.sv]
module lias_mac (
  input  logic             clk,
  input  lias_pkg::mac_op_t op,
  output lias_pkg::acc_t    acc
);
  import lias_pkg::*;

  logic signed [DIFF_W+17-1:0] prod;
  logic signed [DIFF_W+17:0]   sum;

  // The blend u0*(1-f) + u1*f is rewritten as u0*65536 + (u1-u0)*f,
  // which needs a single signed multiply.
  assign prod = op.diff * $signed({1'b0, op.weight});
  assign sum  = $signed({3'b000, op.base, 16'h0000}) + (DIFF_W+18)'(prod);

  always_ff @(posedge clk) begin
    acc <= sum[ACC_W-1:0];
  end

endmodule

[src/linear_interp_audio_resampler_core.sv]
// Linear-interpolation audio resampler. Source frames enter one beat at a time on the input
// channel; the block keeps the previous frame and a 7.16 phase, and for each pair of frames
// it emits blended frames prev*(1-f) + cur*f while the phase is below 1.0, at most
// MAX_UPSAMPLE per pair and no more than main_count per stream. The first frame of a stream
// emits nothing and loads start_phase. A frame marked final_frame is followed by tail_count
// copies of itself (capped at MAX_UPSAMPLE) and closes the stream. run_last marks the last
// output beat caused by an input beat and stream_done the last beat of a stream. All
// arithmetic goes through one shared multiply-accumulate unit, one channel per cycle: an
// output frame passes through S_LEFT, S_RIGHT, S_CAPR (stereo only) and S_EMIT, waiting
// there while the output register is still held by the sink; input is accepted in S_IDLE.
// The input is ready only when the sequencer is idle, so the next input beat is taken once
// the last output of the one before is in the output register, even before the sink takes
// it. Write configuration only while the block is idle.
module linear_interp_audio_resampler_core #(
  parameter int MAX_UPSAMPLE = lias_pkg::LIAS_MAX_UPSAMPLE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  lias_pkg::cfg_index_t   cfg_index,
  input  lias_pkg::cfg_data_t    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lias_pkg::raw_t         left_raw,
  input  lias_pkg::raw_t         right_raw,
  input  logic                   final_frame,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lias_pkg::raw_t         out_left,
  output lias_pkg::raw_t         out_right,
  output logic                   run_last,
  output logic                   stream_done
);
  import lias_pkg::*;

  localparam int KW = $clog2(MAX_UPSAMPLE + 1);

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LEFT  = 5'b00010,
    S_RIGHT = 5'b00100,
    S_CAPR  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Configuration registers.
  logic [PHASE_W-1:0] phase_step;
  logic [START_W-1:0] start_phase;
  logic [COUNT_W-1:0] main_count;
  logic [TAIL_W-1:0]  tail_count;
  logic               is_stereo;
  logic               source_wide;
  logic               source_signed;
  out_fmt_t           out_format;

  // Stream state.
  state_t             state;
  raw_t               prev_left, prev_right;
  raw_t               cur_left, cur_right;
  logic [PHASE_W-1:0] phase_acc;
  logic [COUNT_W-1:0] emitted_main;
  logic               have_prev;
  logic               in_tail;
  logic               item_final;
  logic [KW-1:0]      k_cnt;
  logic [KW-1:0]      tail_cnt;
  raw_t               res_left, res_right;

  // Combinational helpers.
  mac_op_t            mac_op;
  acc_t               mac_acc;
  raw_t               op_prev, op_cur, off_prev, off_cur;
  raw_t               fmt_val;
  logic               in_beat;
  logic               out_free;
  logic [KW-1:0]      tail_n;
  logic               main_go;
  logic [PHASE_W-1:0] phase_wrap;
  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W-1:0] phase_next;
  logic [COUNT_W-1:0] emitted_next;
  logic [KW-1:0]      k_next;
  logic               more_main;
  logic [PHASE_W-1:0] phase_next_wrap;
  logic               result_last;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RST;
      start_phase   <= '0;
      main_count    <= '0;
      tail_count    <= TAIL_COUNT_RST;
      is_stereo     <= 1'b0;
      source_wide   <= 1'b0;
      source_signed <= 1'b0;
      out_format    <= FMT_S16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    phase_step    <= cfg_data[PHASE_W-1:0];
        REG_START_PHASE:   start_phase   <= cfg_data[START_W-1:0];
        REG_MAIN_COUNT:    main_count    <= cfg_data[COUNT_W-1:0];
        REG_TAIL_COUNT:    tail_count    <= cfg_data[TAIL_W-1:0];
        REG_IS_STEREO:     is_stereo     <= cfg_data[0];
        REG_SOURCE_WIDE:   source_wide   <= cfg_data[0];
        REG_SOURCE_SIGNED: source_signed <= cfg_data[0];
        REG_OUT_FORMAT:    out_format    <= out_fmt_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Tail copies owed by a final frame, capped at the per-pair limit.
  always_comb begin
    if (!final_frame) begin
      tail_n = '0;
    end else if (tail_count > TAIL_W'(MAX_UPSAMPLE)) begin
      tail_n = KW'(MAX_UPSAMPLE);
    end else begin
      tail_n = tail_count[KW-1:0];
    end
  end

  // A pair produces main output only when the phase is below 1.0 and the stream quota
  // is not used up.
  assign main_go = have_prev && (phase_acc[PHASE_W-1:16] == '0) &&
                   (emitted_main < main_count);

  // Moving the phase back by 1.0 at the end of a pair; a phase still below 1.0 is forced
  // to 1.0 first, so the next pair starts at zero.
  assign phase_wrap = (phase_acc[PHASE_W-1:16] == '0) ? '0 : (phase_acc - PHASE_ONE);

  // Look ahead one main output so the last beat of an input can be flagged.
  assign phase_sum       = {1'b0, phase_acc} + {1'b0, phase_step};
  assign phase_next      = phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];
  assign emitted_next    = emitted_main + 1'b1;
  assign k_next          = k_cnt + 1'b1;
  assign more_main       = (phase_next[PHASE_W-1:16] == '0) &&
                           (emitted_next < main_count) &&
                           (k_next < KW'(MAX_UPSAMPLE));
  assign phase_next_wrap = (phase_next[PHASE_W-1:16] == '0) ? '0 :
                           (phase_next - PHASE_ONE);
  assign result_last     = in_tail ? (tail_cnt == KW'(1)) :
                           (!more_main && (tail_cnt == '0));

  // Operand selection for the shared unit: left channel while in S_LEFT, right after.
  // A tail copy blends the current frame with itself, so its difference is zero.
  always_comb begin
    op_cur   = (state == S_LEFT) ? cur_left : cur_right;
    op_prev  = in_tail ? op_cur : ((state == S_LEFT) ? prev_left : prev_right);
    off_cur  = to_offset(op_cur, source_wide, source_signed);
    off_prev = to_offset(op_prev, source_wide, source_signed);
    mac_op.base   = off_prev;
    mac_op.diff   = $signed({1'b0, off_cur}) - $signed({1'b0, off_prev});
    mac_op.weight = in_tail ? 16'h0000 : phase_acc[15:0];
  end

  lias_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (mac_acc)
  );

  assign fmt_val = format_out(mac_acc, source_wide, out_format);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_left    <= '0;
      prev_right   <= '0;
      phase_acc    <= '0;
      emitted_main <= '0;
      have_prev    <= 1'b0;
      in_tail      <= 1'b0;
      item_final   <= 1'b0;
      k_cnt        <= '0;
      tail_cnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            cur_left   <= left_raw;
            cur_right  <= right_raw;
            item_final <= final_frame;
            have_prev  <= !final_frame;
            tail_cnt   <= tail_n;
            k_cnt      <= '0;
            if (main_go) begin
              in_tail <= 1'b0;
              state   <= S_LEFT;
            end else begin
              prev_left  <= left_raw;
              prev_right <= right_raw;
              in_tail    <= 1'b1;
              if (!have_prev) begin
                phase_acc    <= {{(PHASE_W-START_W){1'b0}}, start_phase};
                emitted_main <= '0;
              end else begin
                phase_acc <= phase_wrap;
              end
              state <= (tail_n != '0) ? S_LEFT : S_IDLE;
            end
          end
        end
        S_LEFT: begin
          state <= S_RIGHT;
        end
        S_RIGHT: begin
          state <= is_stereo ? S_CAPR : S_EMIT;
        end
        S_CAPR: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (in_tail) begin
              tail_cnt <= tail_cnt - 1'b1;
              state    <= (tail_cnt == KW'(1)) ? S_IDLE : S_LEFT;
            end else begin
              emitted_main <= emitted_next;
              k_cnt        <= k_next;
              if (more_main) begin
                phase_acc <= phase_next;
                state     <= S_LEFT;
              end else begin
                // Pair finished: wrap the phase and shift the current frame into place.
                phase_acc  <= phase_next_wrap;
                prev_left  <= cur_left;
                prev_right <= cur_right;
                in_tail    <= 1'b1;
                state      <= (tail_cnt != '0) ? S_LEFT : S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Channel results from the shared unit.
  always_ff @(posedge clk) begin
    if (state == S_RIGHT) begin
      res_left <= fmt_val;
    end
    if (state == S_CAPR) begin
      res_right <= fmt_val;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_left    <= res_left;
      out_right   <= is_stereo ? res_right : '0;
      run_last    <= result_last;
      stream_done <= result_last && item_final;
    end
  end

endmodule

[tb/resample_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both beat channels of the resampler. It keeps its
// own copy of the registers and of the stream state, works out the output frames each
// accepted source frame should produce, and compares every output beat with the oldest
// frame still owed.
module resample_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  lias_pkg::cfg_index_t cfg_index,
  input  lias_pkg::cfg_data_t  cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lias_pkg::raw_t       left_raw,
  input  lias_pkg::raw_t       right_raw,
  input  logic                 final_frame,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  lias_pkg::raw_t       out_left,
  input  lias_pkg::raw_t       out_right,
  input  logic                 run_last,
  input  logic                 stream_done,
  output int                   mismatches,
  output int                   outstanding
);
  import lias_pkg::*;

  typedef struct packed {
    raw_t left;
    raw_t right;
    logic run_last;
    logic stream_done;
  } out_frame_t;

  localparam logic [31:0] PHASE_CEIL = 32'h007F_FFFF;
  localparam logic [16:0] UNITY = 17'h10000;

  // Register copies.
  logic [PHASE_W-1:0] step_cfg;
  logic [START_W-1:0] start_cfg;
  logic [COUNT_W-1:0] main_limit;
  logic [TAIL_W-1:0]  tail_cfg;
  logic               stereo_cfg;
  logic               wide_cfg;
  logic               signed_cfg;
  out_fmt_t           fmt_cfg;

  // Stream state.
  raw_t        last_left;
  raw_t        last_right;
  logic [31:0] phase;
  logic [31:0] main_done;
  logic        stream_open;

  out_frame_t owed_frames[$];

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  // Offset-binary value of one source sample: the sign bit is flipped for signed data.
  function automatic logic [15:0] offset_bin(raw_t raw);
    if (wide_cfg)
      return {raw[15] ^ signed_cfg, raw[14:0]};
    return {8'h00, raw[7] ^ signed_cfg, raw[6:0]};
  endfunction

  function automatic raw_t mix_sample(raw_t a, raw_t b, logic [16:0] wgt);
    out_fmt_t    fmt;
    int          shift;
    logic [63:0] acc;
    logic [31:0] u;
    logic [31:0] adj;
    fmt = wide_cfg ? FMT_S16 : fmt_cfg;
    // An 8-bit source going to 16-bit output keeps 8 more bits of the blend.
    shift = (!wide_cfg && fmt != FMT_S8 && fmt != FMT_U8) ? 8 : 0;
    acc = 64'(offset_bin(a)) * 64'(UNITY - wgt) + 64'(offset_bin(b)) * 64'(wgt);
    u = 32'(acc >> (16 - shift));
    case (fmt)
      FMT_S8: begin
        adj = u - 32'h80;
        return {8'h00, adj[7:0]};
      end
      FMT_U8: return {8'h00, u[7:0]};
      default: begin
        adj = u - 32'h8000;
        return adj[15:0];
      end
    endcase
  endfunction

  function automatic out_frame_t blend_frame(raw_t la, raw_t lb, raw_t ra, raw_t rb,
                                             logic [16:0] wgt);
    out_frame_t fr;
    fr.left = mix_sample(la, lb, wgt);
    fr.right = stereo_cfg ? mix_sample(ra, rb, wgt) : '0;
    fr.run_last = 1'b0;
    fr.stream_done = 1'b0;
    return fr;
  endfunction

  task automatic predict_frame(raw_t cur_left, raw_t cur_right, logic is_final);
    int         first;
    int         burst;
    int         copies;
    out_frame_t tmp;
    first = owed_frames.size();
    if (!stream_open) begin
      phase = 32'(start_cfg);
      main_done = '0;
    end else begin
      burst = 0;
      while (phase < 32'(PHASE_ONE) && main_done < 32'(main_limit) &&
             burst < LIAS_MAX_UPSAMPLE) begin
        owed_frames.push_back(blend_frame(last_left, cur_left, last_right, cur_right,
                                          phase[16:0]));
        phase = phase + 32'(step_cfg);
        if (phase > PHASE_CEIL)
          phase = PHASE_CEIL;
        main_done++;
        burst++;
      end
      // A pair that ran out of outputs still moves on to the next source frame.
      if (phase < 32'(PHASE_ONE))
        phase = 32'(PHASE_ONE);
      phase = phase - 32'(PHASE_ONE);
    end
    last_left = cur_left;
    last_right = cur_right;
    stream_open = 1'b1;
    if (is_final) begin
      copies = (tail_cfg > LIAS_MAX_UPSAMPLE) ? LIAS_MAX_UPSAMPLE : int'(tail_cfg);
      for (int i = 0; i < copies; i++)
        owed_frames.push_back(blend_frame(cur_left, cur_left, cur_right, cur_right, UNITY));
      stream_open = 1'b0;
      if (owed_frames.size() > first) begin
        tmp = owed_frames.pop_back();
        tmp.stream_done = 1'b1;
        owed_frames.push_back(tmp);
      end
    end
    if (owed_frames.size() > first) begin
      tmp = owed_frames.pop_back();
      tmp.run_last = 1'b1;
      owed_frames.push_back(tmp);
    end
  endtask

  always @(posedge clk) begin
    out_frame_t want;
    if (rst) begin
      step_cfg = PHASE_STEP_RST;
      start_cfg = '0;
      main_limit = '0;
      tail_cfg = TAIL_COUNT_RST;
      stereo_cfg = 1'b0;
      wide_cfg = 1'b0;
      signed_cfg = 1'b0;
      fmt_cfg = FMT_S16;
      last_left = '0;
      last_right = '0;
      phase = '0;
      main_done = '0;
      stream_open = 1'b0;
      owed_frames.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP:    step_cfg = cfg_data[PHASE_W-1:0];
          REG_START_PHASE:   start_cfg = cfg_data[START_W-1:0];
          REG_MAIN_COUNT:    main_limit = cfg_data[COUNT_W-1:0];
          REG_TAIL_COUNT:    tail_cfg = cfg_data[TAIL_W-1:0];
          REG_IS_STEREO:     stereo_cfg = cfg_data[0];
          REG_SOURCE_WIDE:   wide_cfg = cfg_data[0];
          REG_SOURCE_SIGNED: signed_cfg = cfg_data[0];
          REG_OUT_FORMAT:    fmt_cfg = out_fmt_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_frame(left_raw, right_raw, final_frame);
      if (out_valid && out_ready) begin
        if (owed_frames.size() == 0) begin
          flag_mismatch("output beat with nothing owed, left", out_left, 16'h0);
        end else begin
          want = owed_frames.pop_front();
          if (out_left !== want.left)
            flag_mismatch("out_left", out_left, want.left);
          if (out_right !== want.right)
            flag_mismatch("out_right", out_right, want.right);
          if (run_last !== want.run_last)
            flag_mismatch("run_last", 16'(run_last), 16'(want.run_last));
          if (stream_done !== want.stream_done)
            flag_mismatch("stream_done", 16'(stream_done), 16'(want.stream_done));
        end
      end
      outstanding <= owed_frames.size();
    end
  end

endmodule

[tb/tb_linear_interp_audio_resampler_core.sv]
`timescale 1ns / 1ps

// Top of the resampler bench. This module only makes stimulus and gives the verdict; the
// checker beside the block mirrors every register write, predicts the output frames of
// every accepted source beat and counts mismatches.
//
// The run has a directed part that walks through the corner cases of the resampler
// (first frame of a stream, one-frame streams, the per-pair output cap at the smallest
// step, phase saturation at the largest step, main output cut off by the count, the tail
// cap, a final frame that produces nothing, and every output format), followed by random
// phases with a fresh register setting each.
module tb_linear_interp_audio_resampler_core;
  import lias_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 10;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;
  logic       in_valid;
  logic       in_ready;
  raw_t       left_raw;
  raw_t       right_raw;
  logic       final_frame;
  logic       out_valid;
  logic       out_ready;
  raw_t       out_left;
  raw_t       out_right;
  logic       run_last;
  logic       stream_done;

  int mismatches;
  int outstanding;
  int stall_cycles;

  // quiet turns off idling on both sides; hold_off_req asks the receiver for one long stall.
  bit quiet;
  bit hold_off_req;

  linear_interp_audio_resampler_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .left_raw(left_raw),
    .right_raw(right_raw),
    .final_frame(final_frame),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left(out_left),
    .out_right(out_right),
    .run_last(run_last),
    .stream_done(stream_done)
  );

  resample_checker checker_inst (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .left_raw(left_raw),
    .right_raw(right_raw),
    .final_frame(final_frame),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left(out_left),
    .out_right(out_right),
    .run_last(run_last),
    .stream_done(stream_done),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which no beat moves on either channel. The longest
  // legal quiet stretch is the receiver hold-off, well under the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: ready drops in about a third of the cycles unless idling is off. When a
  // hold-off is asked for, ready stays low for a long stretch while the sender keeps
  // offering beats, so the output register fills and the block stops taking input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // One register write per cycle; the enable stays high across a batch of writes.
  task automatic put_reg(cfg_index_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
  endtask

  task automatic apply_setting(int step, int start, int count, int tail, int stereo,
                               int wide, int sgn, out_fmt_t fmt);
    put_reg(REG_PHASE_STEP, step);
    put_reg(REG_START_PHASE, start);
    put_reg(REG_MAIN_COUNT, count);
    put_reg(REG_TAIL_COUNT, tail);
    put_reg(REG_IS_STEREO, stereo);
    put_reg(REG_SOURCE_WIDE, wide);
    put_reg(REG_SOURCE_SIGNED, sgn);
    put_reg(REG_OUT_FORMAT, int'(fmt));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random register setting, biased toward steps that upsample so that most source beats
  // produce several output beats, with the extremes of every register mixed in.
  task automatic random_setting();
    int step;
    int count;
    int tail;
    case ($urandom_range(19))
      0, 1, 2, 3, 4:                 step = $urandom_range(2048, 'h4000);
      5, 6, 7, 8, 9, 10, 11, 12:     step = $urandom_range('h4000, 'h20000);
      13, 14, 15, 16:                step = $urandom_range('h20000, 'h400000);
      17:                            step = $urandom_range(1) ? 2048 : 'h400000;
      18:                            step = 'h7FFFFF;
      default:                       step = $urandom_range(0, 2047);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: count = 'hFFFFFF;
      4, 5, 6:    count = $urandom_range(20, 5000);
      default:    count = $urandom_range(0, 12);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: tail = $urandom_range(0, 4);
      6, 7:             tail = $urandom_range(5, 32);
      default:          tail = $urandom_range(33, 63);
    endcase
    apply_setting(step, $urandom_range('hFFFF), count, tail, $urandom_range(1),
                  $urandom_range(1), $urandom_range(1), out_fmt_t'($urandom_range(3)));
  endtask

  // Offer one source frame and wait until the block takes it. Valid is left high after
  // the beat; the next call either keeps it high or drops it for a short gap.
  task automatic send_frame(raw_t l, raw_t r, logic fin);
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_raw <= l;
    right_raw <= r;
    final_frame <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic raw_t pick_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h007F;
      default: return raw_t'($urandom_range('hFFFF));
    endcase
  endfunction

  // A stream is a run of frames with only the last one marked final. A noisy stream puts
  // the final mark at random, which can split it or leave it open into the next phase.
  task automatic send_stream(int frames, bit noisy);
    logic fin;
    for (int i = 0; i < frames; i++) begin
      fin = noisy ? logic'($urandom_range(1)) : (i == frames - 1);
      send_frame(pick_sample(), pick_sample(), fin);
    end
  endtask

  // Registers change only with the block idle: every owed frame has come out and a few
  // more cycles have passed for a beat that produces nothing.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int count;
    int len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PHASE_STEP;
    cfg_data = '0;
    in_valid = 1'b0;
    left_raw = '0;
    right_raw = '0;
    final_frame = 1'b0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Two-times upsampling of unsigned 8-bit mono into signed 8-bit. Upper raw bits and
    // the right channel carry junk that must be ignored. The last frame is a one-frame
    // stream, which gives only its tail copy.
    settle_block();
    apply_setting('h8000, 0, 'hFFFFFF, 1, 0, 0, 0, FMT_S8);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'h00FF, 16'hFFFF, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(16'h0080, 16'h0000, 1'b1);
    send_frame(16'hFF7F, 16'h1234, 1'b1);

    // Smallest step on signed 16-bit stereo: the second pair hits the per-pair output cap. The
    // requested 8-bit format is overridden by the wide source. With no tail, a one-frame
    // stream produces nothing at all.
    settle_block();
    apply_setting(2048, 'hFFFF, 'hFFFFFF, 0, 1, 1, 1, FMT_U8);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b1);
    send_frame(16'h5555, 16'hAAAA, 1'b1);

    // Largest step: the phase saturates. Main output is limited to three beats and the
    // tail count is far above the cap.
    settle_block();
    apply_setting('h7FFFFF, 'hFFFF, 3, 63, 1, 0, 1, FMT_S16);
    send_stream(4, 1'b0);

    // Main output stops after five beats; the rest of the stream only moves the phase.
    settle_block();
    apply_setting('h4000, 0, 5, 2, 0, 0, 1, FMT_S16_ALT);
    send_stream(4, 1'b0);

    // No main output at all, only the capped tail, in unsigned 8-bit.
    settle_block();
    apply_setting('h10000, 1, 0, 33, 0, 0, 0, FMT_U8);
    send_stream(3, 1'b0);

    // Fractional downsampling of signed 8-bit stereo into signed 8-bit.
    settle_block();
    apply_setting('h18000, 'h8000, 'hFFFFFF, 2, 1, 0, 1, FMT_S8);
    send_stream(3, 1'b0);

    // Random phases. Phase 2 carries the long receiver hold-off on a setting that produces
    // four output beats per source beat; phases 4 and 5 run with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      quiet = (p == 4 || p == 5);
      if (p == 2) begin
        apply_setting('h4000, $urandom_range('hFFFF), 'hFFFFFF, 4, $urandom_range(1), 0, 0,
                      FMT_S16);
        hold_off_req = 1'b1;
      end else begin
        random_setting();
      end
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = $urandom_range(1, 6);
        send_stream(len, $urandom_range(9) == 0);
        count += len;
      end
    end
    quiet = 1'b0;
    settle_block();

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
